// ===== design/three_point_quadratic_fit_unit_macros.svh =====
// Assertion macros shared by the quadratic fit RTL.
// Users must provide i_clk and i_rst_n in the scope of each use.
`ifndef THREE_POINT_QUADRATIC_FIT_UNIT_MACROS_SVH
`define THREE_POINT_QUADRATIC_FIT_UNIT_MACROS_SVH

// Same-cycle implication.
`define TPQ_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tpq_pkg.sv =====
// Types and constants of the three-point quadratic fit unit.
// No dependencies; every other design file but the macro header refers to it by scoped names.
package tpq_pkg;

    localparam int X_FIELD_W = 16;
    localparam int Y_FIELD_W = 24;
    localparam int COEF_W    = 48;
    // Quotient bits developed by the divider chain; one more than the output.
    localparam int QB        = COEF_W + 1;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic signed [X_FIELD_W-1:0] x_first;
        logic signed [Y_FIELD_W-1:0] y_first;
        logic signed [X_FIELD_W-1:0] x_second;
        logic signed [Y_FIELD_W-1:0] y_second;
        logic signed [X_FIELD_W-1:0] x_third;
        logic signed [Y_FIELD_W-1:0] y_third;
    } t_fit_in;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_square;
        logic signed [COEF_W-1:0] coef_linear;
        logic signed [COEF_W-1:0] coef_constant;
        logic                     fit_ok;
        logic                     overflow;
    } t_fit_out;

    // Sideband that follows a division down the cell chain.
    typedef struct packed {
        logic neg;
        logic ovf;
    } t_div_ctl;

endpackage

// ===== design/tpq_div_cell.sv =====
// One restoring-division cell: a compare and subtract of the shifted divisor.
// Depends on tpq_pkg.
module tpq_div_cell #(
    parameter int NUMW  = 91,
    parameter int DW    = 51,
    parameter int SHIFT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [NUMW-1:0]       i_rem,
    input  logic [DW-1:0]         i_den,
    input  logic [tpq_pkg::QB-1:0] i_q,
    input  tpq_pkg::t_div_ctl     i_ctl,
    output logic [NUMW-1:0]       o_rem,
    output logic [DW-1:0]         o_den,
    output logic [tpq_pkg::QB-1:0] o_q,
    output tpq_pkg::t_div_ctl     o_ctl
);

    localparam int CW = (NUMW > DW + tpq_pkg::QB) ? NUMW : DW + tpq_pkg::QB;

    logic [CW-1:0] w_rem_ext;
    logic [CW-1:0] w_den_sh;
    logic          w_hit;
    logic [tpq_pkg::QB-1:0] w_q_set;

    logic [NUMW-1:0]        r_rem;
    logic [DW-1:0]          r_den;
    logic [tpq_pkg::QB-1:0] r_q;
    tpq_pkg::t_div_ctl      r_ctl;

    assign w_rem_ext = CW'(i_rem);
    assign w_den_sh  = CW'(i_den) << SHIFT;
    assign w_hit     = (w_rem_ext >= w_den_sh);
    assign w_q_set   = i_q | (tpq_pkg::QB'(w_hit) << SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem    <= w_hit ? NUMW'(w_rem_ext - w_den_sh) : i_rem;
            r_den    <= i_den;
            r_q      <= w_q_set;
            r_ctl    <= i_ctl;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;
    assign o_ctl = r_ctl;

endmodule

// ===== design/tpq_div.sv =====
// Pipelined fixed-point divider: range check, a chain of division cells,
// then rounding and saturation. Depends on tpq_pkg and tpq_div_cell.
module tpq_div #(
    parameter int NUMW = 91,
    parameter int DW   = 51
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [NUMW-1:0]                  i_num,
    input  logic [DW-1:0]                    i_den,
    input  logic                             i_neg,
    output logic signed [tpq_pkg::COEF_W-1:0] o_coef,
    output logic                             o_ovf
);

    localparam int QB = tpq_pkg::QB;
    localparam int CW = (NUMW > DW + QB) ? NUMW : DW + QB;
    localparam int OW = tpq_pkg::COEF_W;

    logic [NUMW-1:0]   r_rem;
    logic [DW-1:0]     r_den;
    tpq_pkg::t_div_ctl r_ctl;

    logic [NUMW-1:0]   w_rem [0:QB];
    logic [DW-1:0]     w_den [0:QB];
    logic [QB-1:0]     w_q   [0:QB];
    tpq_pkg::t_div_ctl w_ctl [0:QB];

    logic              w_rnd;
    logic [QB:0]       w_mag;
    logic [OW-1:0]     w_coef;
    logic              w_ovf;

    logic [OW-1:0]     r_coef;
    logic              r_ovf;

    // A quotient that cannot fit the cell chain is flagged before division.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem     <= i_num;
            r_den     <= i_den;
            r_ctl.neg <= i_neg;
            r_ctl.ovf <= (CW'(i_num) >= (CW'(i_den) << QB));
        end
    end

    assign w_rem[0] = r_rem;
    assign w_den[0] = r_den;
    assign w_q[0]   = '0;
    assign w_ctl[0] = r_ctl;

    for (genvar g = 0; g < QB; g++) begin : g_cell
        tpq_div_cell #(
            .NUMW  (NUMW),
            .DW    (DW),
            .SHIFT (QB - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[g]),
            .i_den (w_den[g]),
            .i_q   (w_q[g]),
            .i_ctl (w_ctl[g]),
            .o_rem (w_rem[g+1]),
            .o_den (w_den[g+1]),
            .o_q   (w_q[g+1]),
            .o_ctl (w_ctl[g+1])
        );
    end

    always_comb begin
        w_rnd = (((DW+1)'(w_rem[QB][DW-1:0])) << 1) >= (DW+1)'(w_den[QB]);
        w_mag = (QB+1)'(w_q[QB]) + (QB+1)'(w_rnd);
        w_ovf = 1'b0;
        if (w_ctl[QB].ovf) begin
            w_ovf  = 1'b1;
            w_coef = w_ctl[QB].neg ? tpq_pkg::COEF_MIN : tpq_pkg::COEF_MAX;
        end else if (w_ctl[QB].neg) begin
            if (w_mag > (QB+1)'(tpq_pkg::COEF_MIN)) begin
                w_ovf  = 1'b1;
                w_coef = tpq_pkg::COEF_MIN;
            end else begin
                w_coef = OW'((QB+1)'(0) - w_mag);
            end
        end else begin
            if (w_mag > (QB+1)'(tpq_pkg::COEF_MAX)) begin
                w_ovf  = 1'b1;
                w_coef = tpq_pkg::COEF_MAX;
            end else begin
                w_coef = OW'(w_mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coef <= w_coef;
            r_ovf  <= w_ovf;
        end
    end

    assign o_coef = $signed(r_coef);
    assign o_ovf  = r_ovf;

endmodule

// ===== design/three_point_quadratic_fit_unit.sv =====
// Three-point quadratic fit: five arithmetic stages, a range check, 49 division
// cells, rounding and the output register; one fit per cycle unless the output stalls.
// The three dividers' cell chains set the latency; the whole pipe stalls only
// while a result waits at the output. Synchronous active-low reset clears valids.
// Depends on tpq_pkg, tpq_div and the assertion macro header.
`include "three_point_quadratic_fit_unit_macros.svh"

module three_point_quadratic_fit_unit #(
    parameter int X_WIDTH   = 16,
    parameter int Y_WIDTH   = 24,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tpq_pkg::t_fit_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tpq_pkg::t_fit_out o_out_data
);

    localparam int XE   = (X_WIDTH < tpq_pkg::X_FIELD_W) ? X_WIDTH : tpq_pkg::X_FIELD_W;
    localparam int YE   = (Y_WIDTH < tpq_pkg::Y_FIELD_W) ? Y_WIDTH : tpq_pkg::Y_FIELD_W;
    localparam int D1   = XE + 1;
    localparam int SQW  = 2 * XE;
    localparam int DDW  = 2 * XE + 2;
    localparam int TAW  = XE + YE + 1;
    localparam int SW   = 2 * XE + 1;
    localparam int AW   = 3 * XE + 1;
    localparam int DW   = 3 * XE + 3;
    localparam int NAW  = XE + YE + 3;
    localparam int TBW  = 2 * XE + YE + 1;
    localparam int TCW  = 3 * XE + YE + 1;
    localparam int NBW  = 2 * XE + YE + 3;
    localparam int NW   = 3 * XE + YE + 3;
    localparam int NUMW = NW + FRAC_BITS;
    localparam int DIV_LAT = tpq_pkg::QB + 2;
    localparam int STG  = 5 + DIV_LAT;

    logic w_en;

    logic signed [XE-1:0] w_x1, w_x2, w_x3;
    logic signed [YE-1:0] w_y1, w_y2, w_y3;

    // Stage 1
    logic signed [D1-1:0]  r_d12, r_d13, r_d23;
    logic signed [SQW-1:0] r_sq1, r_sq2, r_sq3, r_p12, r_p13, r_p23;
    logic signed [YE-1:0]  r_y1, r_y2, r_y3;
    // Stage 2
    logic signed [DDW-1:0] r_dd;
    logic signed [D1-1:0]  r_d23b;
    logic signed [TAW-1:0] r_ta1, r_ta2, r_ta3;
    logic signed [SW-1:0]  r_s1, r_s2, r_s3;
    logic signed [AW-1:0]  r_a1, r_a2, r_a3;
    logic signed [YE-1:0]  r_y1b, r_y2b, r_y3b;
    // Stage 3
    logic signed [DW-1:0]  r_det3;
    logic signed [NAW-1:0] r_na3;
    logic signed [TBW-1:0] r_tb1, r_tb2, r_tb3;
    logic signed [TCW-1:0] r_tc1, r_tc2, r_tc3;
    // Stage 4
    logic signed [DW-1:0]  r_det4;
    logic signed [NAW-1:0] r_na4;
    logic signed [NBW-1:0] r_nb4;
    logic signed [NW-1:0]  r_nc4;
    // Stage 5
    logic [NW-1:0] r_mag_a, r_mag_b, r_mag_c;
    logic [DW-1:0] r_den;
    logic          r_neg_a, r_neg_b, r_neg_c;
    logic          r_zero;

    logic signed [NW-1:0] w_na_ext, w_nb_ext;
    logic signed [DW-1:0] w_det_neg;

    logic [DIV_LAT-1:0] r_zdl;
    logic [STG-1:0]     r_vld;

    logic signed [tpq_pkg::COEF_W-1:0] w_ca, w_cb, w_cc;
    logic                              w_oa, w_ob, w_oc;

    logic              r_out_valid;
    tpq_pkg::t_fit_out r_out;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_x1 = $signed(i_in_data.x_first[XE-1:0]);
    assign w_x2 = $signed(i_in_data.x_second[XE-1:0]);
    assign w_x3 = $signed(i_in_data.x_third[XE-1:0]);
    assign w_y1 = $signed(i_in_data.y_first[YE-1:0]);
    assign w_y2 = $signed(i_in_data.y_second[YE-1:0]);
    assign w_y3 = $signed(i_in_data.y_third[YE-1:0]);

    assign w_na_ext  = NW'(r_na4);
    assign w_nb_ext  = NW'(r_nb4);
    assign w_det_neg = -r_det4;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d12 <= D1'(w_x1) - D1'(w_x2);
            r_d13 <= D1'(w_x1) - D1'(w_x3);
            r_d23 <= D1'(w_x2) - D1'(w_x3);
            r_sq1 <= SQW'(w_x1) * SQW'(w_x1);
            r_sq2 <= SQW'(w_x2) * SQW'(w_x2);
            r_sq3 <= SQW'(w_x3) * SQW'(w_x3);
            r_p12 <= SQW'(w_x1) * SQW'(w_x2);
            r_p13 <= SQW'(w_x1) * SQW'(w_x3);
            r_p23 <= SQW'(w_x2) * SQW'(w_x3);
            r_y1  <= w_y1;
            r_y2  <= w_y2;
            r_y3  <= w_y3;

            r_dd   <= DDW'(r_d12) * DDW'(r_d13);
            r_d23b <= r_d23;
            r_ta1  <= TAW'(r_d23) * TAW'(r_y1);
            r_ta2  <= TAW'(r_d13) * TAW'(r_y2);
            r_ta3  <= TAW'(r_d12) * TAW'(r_y3);
            r_s1   <= SW'(r_sq3) - SW'(r_sq2);
            r_s2   <= SW'(r_sq1) - SW'(r_sq3);
            r_s3   <= SW'(r_sq2) - SW'(r_sq1);
            r_a1   <= AW'(r_p23) * AW'(r_d23);
            r_a2   <= AW'(r_p13) * AW'(r_d13);
            r_a3   <= AW'(r_p12) * AW'(r_d12);
            r_y1b  <= r_y1;
            r_y2b  <= r_y2;
            r_y3b  <= r_y3;

            r_det3 <= DW'(r_dd) * DW'(r_d23b);
            r_na3  <= NAW'(r_ta1) - NAW'(r_ta2) + NAW'(r_ta3);
            r_tb1  <= TBW'(r_s1) * TBW'(r_y1b);
            r_tb2  <= TBW'(r_s2) * TBW'(r_y2b);
            r_tb3  <= TBW'(r_s3) * TBW'(r_y3b);
            r_tc1  <= TCW'(r_a1) * TCW'(r_y1b);
            r_tc2  <= TCW'(r_a2) * TCW'(r_y2b);
            r_tc3  <= TCW'(r_a3) * TCW'(r_y3b);

            r_det4 <= r_det3;
            r_na4  <= r_na3;
            r_nb4  <= NBW'(r_tb1) + NBW'(r_tb2) + NBW'(r_tb3);
            r_nc4  <= NW'(r_tc1) - NW'(r_tc2) + NW'(r_tc3);

            // Sign and magnitude for the unsigned divider.
            r_mag_a <= w_na_ext[NW-1] ? $unsigned(-w_na_ext) : $unsigned(w_na_ext);
            r_mag_b <= w_nb_ext[NW-1] ? $unsigned(-w_nb_ext) : $unsigned(w_nb_ext);
            r_mag_c <= r_nc4[NW-1] ? $unsigned(-r_nc4) : $unsigned(r_nc4);
            r_den   <= r_det4[DW-1] ? $unsigned(w_det_neg) : $unsigned(r_det4);
            r_neg_a <= r_na4[NAW-1] ^ r_det4[DW-1];
            r_neg_b <= r_nb4[NBW-1] ^ r_det4[DW-1];
            r_neg_c <= r_nc4[NW-1] ^ r_det4[DW-1];
            r_zero  <= (r_det4 == '0);

            r_zdl <= {r_zdl[DIV_LAT-2:0], r_zero};
        end
    end

    tpq_div #(.NUMW(NUMW), .DW(DW)) u_div_a (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (NUMW'(r_mag_a) << FRAC_BITS), .i_den (r_den), .i_neg (r_neg_a),
        .o_coef (w_ca), .o_ovf (w_oa)
    );

    tpq_div #(.NUMW(NUMW), .DW(DW)) u_div_b (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (NUMW'(r_mag_b) << FRAC_BITS), .i_den (r_den), .i_neg (r_neg_b),
        .o_coef (w_cb), .o_ovf (w_ob)
    );

    tpq_div #(.NUMW(NUMW), .DW(DW)) u_div_c (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (NUMW'(r_mag_c) << FRAC_BITS), .i_den (r_den), .i_neg (r_neg_c),
        .o_coef (w_cc), .o_ovf (w_oc)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_zdl[DIV_LAT-1]) begin
                r_out <= '0;
            end else begin
                r_out.coef_square   <= w_ca;
                r_out.coef_linear   <= w_cb;
                r_out.coef_constant <= w_cc;
                r_out.fit_ok        <= 1'b1;
                r_out.overflow      <= w_oa || w_ob || w_oc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[STG-2:0], i_in_valid};
            r_out_valid <= r_vld[STG-1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TPQ_ASSERT_HOLDS(a_nofit_zero, o_out_valid && !o_out_data.fit_ok, o_out_data.coef_square == '0 && o_out_data.coef_linear == '0 && o_out_data.coef_constant == '0 && !o_out_data.overflow, "unfitted result carries nonzero data")
    `TPQ_ASSERT_HOLDS(a_ovf_needs_fit, o_out_valid && o_out_data.overflow, o_out_data.fit_ok, "overflow flagged on unfitted result")
    `TPQ_ASSERT_HOLDS(a_stall_blocks, o_out_valid && !i_out_ready, !o_in_ready, "input taken while pipe is stalled")
    `TPQ_ASSERT_NEXT(a_enter_pipe, i_in_valid && o_in_ready, r_vld[0], "accepted transaction did not enter the pipe")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the three-point quadratic fit unit.
// Depends on tpq_pkg and the three_point_quadratic_fit_unit RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 57;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    tpq_pkg::t_fit_in  in_data;
    logic              out_valid;
    logic              out_ready;
    tpq_pkg::t_fit_out out_data;

    three_point_quadratic_fit_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    tpq_pkg::t_fit_in  pending_fits[$];
    tpq_pkg::t_fit_out expected_coefs[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_sender;
    int       error_count;
    int       fits_checked;
    int       bad_fits;
    int       saturated_fits;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Divides num * 2^16 by den, rounded half away from zero, saturated to 48 bits.
    function automatic logic [tpq_pkg::COEF_W-1:0] fixed_quotient(
            input logic signed [159:0] num,
            input logic signed [159:0] den,
            inout logic ovf);
        logic [159:0] n_mag;
        logic [159:0] d_mag;
        logic [159:0] q;
        logic [159:0] r;
        logic         neg;
        neg   = (num < 0) != (den < 0);
        n_mag = (num < 0) ? -num : num;
        d_mag = (den < 0) ? -den : den;
        n_mag = n_mag << 16;
        q = n_mag / d_mag;
        r = n_mag % d_mag;
        if ((r << 1) >= d_mag) q = q + 1;
        if (neg) begin
            if (q > 160'h8000_0000_0000) begin
                ovf = 1'b1;
                return tpq_pkg::COEF_MIN;
            end
            return -q[tpq_pkg::COEF_W-1:0];
        end
        if (q > 160'h7FFF_FFFF_FFFF) begin
            ovf = 1'b1;
            return tpq_pkg::COEF_MAX;
        end
        return q[tpq_pkg::COEF_W-1:0];
    endfunction

    function automatic tpq_pkg::t_fit_out fit_parabola(input tpq_pkg::t_fit_in p);
        logic signed [159:0] x1, x2, x3, y1, y2, y3;
        logic signed [159:0] d12, d13, d23, det, na, nb, nc;
        tpq_pkg::t_fit_out res;
        logic ovf;
        x1 = p.x_first;  x2 = p.x_second; x3 = p.x_third;
        y1 = p.y_first;  y2 = p.y_second; y3 = p.y_third;
        d12 = x1 - x2; d13 = x1 - x3; d23 = x2 - x3;
        det = d12 * d13 * d23;
        res = '0;
        if (det == 0) return res;
        ovf = 1'b0;
        na = d23 * y1 - d13 * y2 + d12 * y3;
        nb = (x3 * x3 - x2 * x2) * y1 + (x1 * x1 - x3 * x3) * y2 + (x2 * x2 - x1 * x1) * y3;
        nc = x2 * x3 * d23 * y1 - x1 * x3 * d13 * y2 + x1 * x2 * d12 * y3;
        res.coef_square   = fixed_quotient(na, det, ovf);
        res.coef_linear   = fixed_quotient(nb, det, ovf);
        res.coef_constant = fixed_quotient(nc, det, ovf);
        res.fit_ok   = 1'b1;
        res.overflow = ovf;
        return res;
    endfunction

    function automatic tpq_pkg::t_fit_in make_fit(input int x1, input int y1, input int x2,
                                                  input int y2, input int x3, input int y3);
        tpq_pkg::t_fit_in p;
        p.x_first = x1[15:0]; p.y_first = y1[23:0];
        p.x_second = x2[15:0]; p.y_second = y2[23:0];
        p.x_third = x3[15:0]; p.y_third = y3[23:0];
        return p;
    endfunction

    function automatic logic [15:0] pick_x();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 40) - 20);
            2: return $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(0, 3))
                                            : 16'(16'h8000 + $urandom_range(0, 3));
            default: return 16'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    function automatic logic [23:0] pick_y();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            1: return 24'($urandom_range(0, 200) - 100);
            default: return 24'($urandom());
        endcase
    endfunction

    // Driver: valid stays up with a stable payload until the transaction is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) expected_coefs.push_back(fit_parabola(in_data));
            if (pending_fits.size() > 0 && !hold_sender
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= pending_fits.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ready <= 1'b0;
        else          out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor.
    always @(posedge i_clk) begin
        tpq_pkg::t_fit_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_coefs.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_data);
                error_count++;
            end else begin
                want = expected_coefs.pop_front();
                fits_checked++;
                if (!want.fit_ok) bad_fits++;
                if (want.overflow) saturated_fits++;
                if (out_data.coef_square !== want.coef_square)
                    $display("%0t: coef_square expected %h actual %h",
                             $time, want.coef_square, out_data.coef_square);
                if (out_data.coef_linear !== want.coef_linear)
                    $display("%0t: coef_linear expected %h actual %h",
                             $time, want.coef_linear, out_data.coef_linear);
                if (out_data.coef_constant !== want.coef_constant)
                    $display("%0t: coef_constant expected %h actual %h",
                             $time, want.coef_constant, out_data.coef_constant);
                if (out_data.fit_ok !== want.fit_ok)
                    $display("%0t: fit_ok expected %b actual %b",
                             $time, want.fit_ok, out_data.fit_ok);
                if (out_data.overflow !== want.overflow)
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.overflow, out_data.overflow);
                if (out_data !== want) error_count++;
            end
        end
    end

    task automatic drain();
        while (pending_fits.size() > 0 || in_valid || expected_coefs.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int x1, x2, x3;
        i_rst_n = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 50;
        hold_sender = 1'b0;
        error_count = 0;
        fits_checked = 0;
        bad_fits = 0;
        saturated_fits = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: simple parabolas, repeated abscissas, extremes, saturation.
        pending_fits.push_back(make_fit(0, 0, 1, 1, 2, 4));
        pending_fits.push_back(make_fit(-1, 3, 0, 1, 1, 3));
        pending_fits.push_back(make_fit(0, 1, 1, 2, 3, 7));
        pending_fits.push_back(make_fit(5, 1, 5, 2, 7, 3));
        pending_fits.push_back(make_fit(5, 1, 7, 2, 7, 3));
        pending_fits.push_back(make_fit(4, 1, 7, 2, 4, 3));
        pending_fits.push_back(make_fit(9, 9, 9, 9, 9, 9));
        pending_fits.push_back(make_fit(-32768, -8388608, 0, 8388607, 32767, -8388608));
        pending_fits.push_back(make_fit(32767, 8388607, -32768, 8388607, 1, -8388608));
        pending_fits.push_back(make_fit(0, -8388608, 1, 8388607, 2, -8388608));
        pending_fits.push_back(make_fit(32765, 8388607, 32766, -8388608, 32767, 8388607));
        pending_fits.push_back(make_fit(-32768, 8388607, -32767, -8388608, -32766, 8388607));
        pending_fits.push_back(make_fit(0, 0, 1, 0, 2, 0));
        pending_fits.push_back(make_fit(0, 1, 3, 0, 6, 0));
        pending_fits.push_back(make_fit(0, 0, 2, 1, 4, 0));
        pending_fits.push_back(make_fit(-1, -1, 0, 0, 1, 1));
        pending_fits.push_back(make_fit(-32768, 1, -32768, 2, 32767, 3));
        pending_fits.push_back(make_fit(100, 12345, -200, -54321, 300, 777));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 27 : 0;
            for (int k = 0; k < 280; k++) begin
                x1 = int'($signed(pick_x()));
                x2 = int'($signed(pick_x()));
                x3 = int'($signed(pick_x()));
                if ($urandom_range(0, 15) == 0) x2 = x1;
                pending_fits.push_back(make_fit(x1, int'($signed(pick_y())),
                                                x2, int'($signed(pick_y())),
                                                x3, int'($signed(pick_y()))));
            end
            if (phase == 0) begin
                // Hold the sender until the pipe has fully emptied once.
                while (pending_fits.size() > 140) @(posedge i_clk);
                hold_sender = 1'b1;
                while (in_valid || expected_coefs.size() > 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            drain();
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Checked %0d fits, %0d with repeated abscissas, %0d saturated.",
                 fits_checked, bad_fits, saturated_fits);
        if (error_count == 0 && expected_coefs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
